FILE: design/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PRE_ASSERT(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define PRE_IMPLY(lbl, clk, rst_n, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
`define PRE_NEXT(lbl, clk, rst_n, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`else
`define PRE_ASSERT(lbl, clk, rst_n, cond, msg)
`define PRE_IMPLY(lbl, clk, rst_n, a, b, msg)
`define PRE_NEXT(lbl, clk, rst_n, a, b, msg)
`endif
`endif

FILE: design/pre_pkg.sv
package pre_pkg;
    localparam int CW = 32;
    localparam int IW = 16;
    localparam int LW = 40;
    localparam int SQW = 2 * CW + 2;
    localparam int RW = CW + 1;
    localparam int PW = CW + 20;
    localparam logic [LW-1:0] LEN_MAX = '1;
    localparam logic [19:0] HW_RESET = 20'd3840;
    localparam logic [15:0] MSL_RESET = 16'd3;
    localparam logic [0:0] ADDR_HW = 1'b0;
    localparam logic [0:0] ADDR_MSL = 1'b1;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } unit_ctl_t;
endpackage

FILE: design/polyline_ribbon_extruder.sv
// channel | direction | handshake       | word
// point   | in        | valid / ready   | point_x/y/z, end_of_line
// result  | out       | out_valid/ready | kind, vertex_*, tex_*, index_*, flags
// config  | in        | apb             | half_width, min_segment_length
// a point with a previous point runs squares and sum, a serial root and a
// check; a kept segment adds two serial divides and six output words, and no
// new point is taken until the current one has been through these steps
// the first point of a line goes straight to the done state; results drain one per cycle while out_ready is high
// reset clears line state and loads register defaults; no clearing pass
// a stalled result holds the output register and the emit state; the last
// word of a segment may still wait there while the next point is taken
`include "assert_macros.svh"
module polyline_ribbon_extruder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:2]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        valid,
    output logic        ready,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    input  logic        end_of_line,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic signed [31:0] vertex_x,
    output logic signed [31:0] vertex_y,
    output logic signed [31:0] vertex_z,
    output logic        tex_u,
    output logic [39:0] tex_v,
    output logic [15:0] index_a,
    output logic [15:0] index_b,
    output logic [15:0] index_c,
    output logic        index_wrapped,
    output logic        last
);
    localparam int CW = pre_pkg::CW;
    localparam int RW = pre_pkg::RW;
    localparam int PW = pre_pkg::PW;
    localparam int SQW = pre_pkg::SQW;

    localparam logic [3:0] S_IDLE = 4'd0, S_SQ = 4'd1, S_SUM = 4'd2,
        S_ROOT = 4'd3, S_CHK = 4'd4, S_DZ = 4'd5, S_DX = 4'd6,
        S_EMIT = 4'd7, S_DONE = 4'd8, S_SQW = 4'd9;

    // config registers
    logic [19:0] hw_reg;
    logic [15:0] msl_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hw_reg  <= pre_pkg::HW_RESET;
            msl_reg <= pre_pkg::MSL_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[2])
                pre_pkg::ADDR_HW:  hw_reg  <= pwdata[19:0];
                pre_pkg::ADDR_MSL: msl_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end
    assign pready = 1'b1;
    assign prdata = (paddr[2] == pre_pkg::ADDR_HW) ? {12'd0, hw_reg} : {16'd0, msl_reg};

    // line state
    logic [3:0]             state_reg;
    logic signed [CW-1:0]   px_reg, py_reg, pz_reg, cx_reg, cy_reg, cz_reg;
    logic                   eol_reg, have_reg, wrap_reg;
    logic [pre_pkg::LW-1:0] rl_reg, v1_reg;
    logic [pre_pkg::IW-1:0] vc_reg;
    logic [CW:0]            ax_reg, ay_reg, az_reg;
    logic                   dxneg_reg, dzpos_reg;
    logic [SQW-1:0]         sq_reg;
    logic [2*CW+1:0]        mx_reg, my_reg, mz_reg;
    logic [RW-1:0]          len_reg;
    logic [PW-1:0]          qx_reg, qz_reg;
    logic [2:0]             slot_reg;

    logic signed [CW:0] dx, dy, dz;
    assign dx = {cx_reg[CW-1], cx_reg} - {px_reg[CW-1], px_reg};
    assign dy = {cy_reg[CW-1], cy_reg} - {py_reg[CW-1], py_reg};
    assign dz = {cz_reg[CW-1], cz_reg} - {pz_reg[CW-1], pz_reg};

    // divider operand: |d| * half_width
    logic [PW-1:0] prod_reg;
    pre_pkg::unit_ctl_t sq_ctl, dv_ctl;
    logic [RW-1:0] root;
    logic [PW-1:0] quot;

    pre_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .start(sq_ctl.start), .radicand(sq_reg),
        .busy(sq_ctl.busy), .done(sq_ctl.done), .root(root));
    pre_div u_div (.clk(clk), .rst_n(rst_n), .start(dv_ctl.start), .dividend(prod_reg),
        .divisor(len_reg), .busy(dv_ctl.busy), .done(dv_ctl.done), .quotient(quot));

    // root unit starts the cycle after the sum is registered
    logic sq_go_reg;
    assign sq_ctl.start = sq_go_reg;
    logic div_go_reg;
    assign dv_ctl.start = div_go_reg;

    // output word
    logic out_valid_reg;
    logic ld;
    logic signed [CW+PW:0] ox, oz, bx, bz, sx, sz;
    logic [pre_pkg::IW-1:0] s0;
    assign s0 = vc_reg;

    function automatic logic [CW-1:0] sat(input logic signed [CW+PW:0] v);
        logic signed [CW+PW:0] hi, lo;
        hi = (CW+PW+1)'({1'b0, {(CW-1){1'b1}}});
        lo = -hi - 1;
        if (v > hi) return hi[CW-1:0];
        if (v < lo) return lo[CW-1:0];
        return v[CW-1:0];
    endfunction

    always_comb
    begin
        ox = dzpos_reg ? -$signed({1'b0, qz_reg}) : $signed({1'b0, qz_reg});
        oz = dxneg_reg ? -$signed({1'b0, qx_reg}) : $signed({1'b0, qx_reg});
        bx = slot_reg[1] ? (CW+PW+1)'(cx_reg) : (CW+PW+1)'(px_reg);
        bz = slot_reg[1] ? (CW+PW+1)'(cz_reg) : (CW+PW+1)'(pz_reg);
        sx = slot_reg[0] ? bx - ox : bx + ox;
        sz = slot_reg[0] ? bz - oz : bz + oz;
    end

    assign ld = (state_reg == S_EMIT) && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ld)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            index_wrapped <= wrap_reg;
            last          <= (slot_reg == 3'd5);
            if (slot_reg[2])
            begin
                kind     <= 1'b1;
                vertex_x <= '0;
                vertex_y <= '0;
                vertex_z <= '0;
                tex_u    <= 1'b0;
                tex_v    <= '0;
                index_a  <= slot_reg[0] ? s0 + 16'd1 : s0;
                index_b  <= slot_reg[0] ? s0 + 16'd3 : s0 + 16'd1;
                index_c  <= s0 + 16'd2;
            end
            else
            begin
                kind     <= 1'b0;
                vertex_x <= sat(sx);
                vertex_y <= slot_reg[1] ? cy_reg : py_reg;
                vertex_z <= sat(sz);
                tex_u    <= slot_reg[0];
                tex_v    <= slot_reg[1] ? v1_reg : rl_reg;
                index_a  <= '0;
                index_b  <= '0;
                index_c  <= '0;
            end
        end
    end
    assign out_valid = out_valid_reg;

    assign ready = (state_reg == S_IDLE);

    logic [pre_pkg::IW:0] nx;
    assign nx = {1'b0, vc_reg} + (pre_pkg::IW+1)'(4);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            have_reg   <= 1'b0;
            wrap_reg   <= 1'b0;
            rl_reg     <= '0;
            vc_reg     <= '0;
            px_reg     <= '0;
            py_reg     <= '0;
            pz_reg     <= '0;
            slot_reg   <= '0;
            div_go_reg <= 1'b0;
            sq_go_reg  <= 1'b0;
        end
        else
        begin
            div_go_reg <= 1'b0;
            sq_go_reg  <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                    if (valid)
                    begin
                        cx_reg    <= point_x;
                        cy_reg    <= point_y;
                        cz_reg    <= point_z;
                        eol_reg   <= end_of_line;
                        state_reg <= have_reg ? S_SQ : S_DONE;
                    end
                S_SQ:
                begin
                    ax_reg    <= dx[CW] ? (CW+1)'(-dx) : dx;
                    ay_reg    <= dy[CW] ? (CW+1)'(-dy) : dy;
                    az_reg    <= dz[CW] ? (CW+1)'(-dz) : dz;
                    dxneg_reg <= dx[CW];
                    dzpos_reg <= !dz[CW] && (dz != '0);
                    state_reg <= S_SQW;
                end
                S_SQW:
                begin
                    mx_reg    <= ax_reg * ax_reg;
                    my_reg    <= ay_reg * ay_reg;
                    mz_reg    <= az_reg * az_reg;
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    sq_go_reg <= 1'b1;
                    state_reg <= S_ROOT;
                end
                S_ROOT:
                    if (sq_ctl.done)
                    begin
                        len_reg   <= root;
                        state_reg <= S_CHK;
                    end
                S_CHK:
                    if (len_reg == '0 || len_reg < RW'(msl_reg))
                        state_reg <= S_DONE;
                    else
                    begin
                        prod_reg   <= PW'(az_reg) * PW'(hw_reg);
                        div_go_reg <= 1'b1;
                        v1_reg     <= (pre_pkg::LEN_MAX - rl_reg < pre_pkg::LW'(len_reg))
                                      ? pre_pkg::LEN_MAX : rl_reg + pre_pkg::LW'(len_reg);
                        state_reg  <= S_DZ;
                    end
                S_DZ:
                    if (dv_ctl.done)
                    begin
                        qz_reg     <= quot;
                        prod_reg   <= PW'(ax_reg) * PW'(hw_reg);
                        div_go_reg <= 1'b1;
                        state_reg  <= S_DX;
                    end
                S_DX:
                    if (dv_ctl.done)
                    begin
                        qx_reg    <= quot;
                        slot_reg  <= '0;
                        state_reg <= S_EMIT;
                    end
                S_EMIT:
                    if (ld)
                    begin
                        slot_reg <= slot_reg + 3'd1;
                        if (slot_reg == 3'd5)
                        begin
                            if (nx[pre_pkg::IW]) wrap_reg <= 1'b1;
                            vc_reg    <= nx[pre_pkg::IW-1:0];
                            rl_reg    <= v1_reg;
                            state_reg <= S_DONE;
                        end
                    end
                S_DONE:
                begin
                    px_reg    <= cx_reg;
                    py_reg    <= cy_reg;
                    pz_reg    <= cz_reg;
                    have_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                    if (eol_reg)
                    begin
                        px_reg   <= '0;
                        py_reg   <= '0;
                        pz_reg   <= '0;
                        have_reg <= 1'b0;
                        wrap_reg <= 1'b0;
                        rl_reg   <= '0;
                        vc_reg   <= '0;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // sum of squares registered ahead of the root unit start
    logic [SQW-1:0] sqsum;
    assign sqsum = SQW'(mx_reg) + SQW'(my_reg) + SQW'(mz_reg);

    always_ff @(posedge clk)
    begin
        if (state_reg == S_SUM)
            sq_reg <= sqsum;
    end

    `PRE_IMPLY(a_ready_idle, clk, rst_n, ready, !sq_ctl.busy && !dv_ctl.busy, "busy unit while ready")
    `PRE_IMPLY(a_emit_len, clk, rst_n, state_reg == S_EMIT, len_reg != '0, "emit with zero length")
    `PRE_NEXT(a_last_slot, clk, rst_n, ld && slot_reg == 3'd5, state_reg == S_DONE, "missed done")
endmodule

FILE: design/pre_sqrt.sv
// bit-serial square root, two radicand bits per cycle
module pre_sqrt (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [pre_pkg::SQW-1:0] radicand,
    output logic                   busy,
    output logic                   done,
    output logic [pre_pkg::RW-1:0] root
);
    localparam int STEPS = pre_pkg::SQW / 2;
    localparam int CNTW = $clog2(STEPS + 1);

    logic [pre_pkg::SQW-1:0] rad_reg;
    logic [pre_pkg::RW+1:0]  rem_reg;
    logic [pre_pkg::RW-1:0]  root_reg;
    logic [CNTW-1:0]         cnt_reg;
    logic                    busy_reg, done_reg;
    logic [pre_pkg::RW+1:0]  trial, shifted;

    always_comb
    begin
        shifted = {rem_reg[pre_pkg::RW-1:0], rad_reg[pre_pkg::SQW-1 -: 2]};
        trial   = {root_reg, 2'b01};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= {rad_reg[pre_pkg::SQW-3:0], 2'b00};
            if (shifted >= trial)
            begin
                rem_reg  <= shifted - trial;
                root_reg <= {root_reg[pre_pkg::RW-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= shifted;
                root_reg <= {root_reg[pre_pkg::RW-2:0], 1'b0};
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign root = root_reg;
endmodule

FILE: design/pre_div.sv
// restoring divider, one quotient bit per cycle
module pre_div (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [pre_pkg::PW-1:0] dividend,
    input  logic [pre_pkg::RW-1:0] divisor,
    output logic                   busy,
    output logic                   done,
    output logic [pre_pkg::PW-1:0] quotient
);
    localparam int CNTW = $clog2(pre_pkg::PW + 1);

    logic [pre_pkg::PW-1:0] q_reg;
    logic [pre_pkg::RW:0]   rem_reg;
    logic [pre_pkg::RW-1:0] den_reg;
    logic [CNTW-1:0]        cnt_reg;
    logic                   busy_reg, done_reg;
    logic [pre_pkg::RW:0]   sh;

    assign sh = {rem_reg[pre_pkg::RW-1:0], q_reg[pre_pkg::PW-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(pre_pkg::PW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (sh >= {1'b0, den_reg})
            begin
                rem_reg <= sh - {1'b0, den_reg};
                q_reg   <= {q_reg[pre_pkg::PW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= sh;
                q_reg   <= {q_reg[pre_pkg::PW-2:0], 1'b0};
            end
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = q_reg;
endmodule
